[rtl/drag_detent_quantizer_assert.svh]
// ----------------------------------------------------------------------------
// drag_detent_quantizer assertion macros
// Short forms for clocked properties with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DRAG_DETENT_QUANTIZER_ASSERT_SVH
`define DRAG_DETENT_QUANTIZER_ASSERT_SVH

// same-cycle implication
`define DDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/ddq_pkg.sv]
// ----------------------------------------------------------------------------
// ddq_pkg
// Widths, build constants and types of the drag detent quantizer.
// ----------------------------------------------------------------------------
package ddq_pkg;

    localparam int GAIN_BASE       = 4;
    localparam int PIXELS_PER_STEP = 34;

    localparam int POS_W   = 16;
    localparam int GAIN_W  = 15;
    localparam int OUT_W   = 11;
    localparam int PROD_W  = 32;
    localparam int NUM_W   = 17;
    localparam int Q_W     = 11;
    localparam int TDATA_W = 16;
    localparam int OTDATA_W = 16;

    localparam logic [GAIN_W-1:0] MAX_GAIN_RESET = GAIN_W'(16);

    // floor((res + HALF_OFS) / PITCH) done on a biased, non-negative value
    localparam int HALF_OFS   = PIXELS_PER_STEP / 2 - 1;
    localparam int BIAS_STEPS = 32768 / PIXELS_PER_STEP + 1;
    localparam int BIAS       = BIAS_STEPS * PIXELS_PER_STEP;

    // reciprocal: exact while u * (MULT * PITCH - 2^SHIFT) < 2^SHIFT
    localparam int DIV_SHIFT = 23;
    localparam int DIV_MULT  = (2 ** DIV_SHIFT + PIXELS_PER_STEP - 1) / PIXELS_PER_STEP;
    localparam int MULT_W    = $clog2(DIV_MULT + 1);
    localparam int QPROD_W   = NUM_W + MULT_W;

    typedef enum logic [1:0] {
        KIND_RELEASE,
        KIND_LATCH,
        KIND_MOVE
    } t_kind;

endpackage

[rtl/drag_detent_quantizer.sv]
// ----------------------------------------------------------------------------
// drag_detent_quantizer
// Turns vertical touch drags into signed detent step counts.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the master side accepts results;
// three register stages (delta/gain, gain multiply, residual add with
// reciprocal divide) each hold one item.
// The residual loop closes inside the last stage only.
// Reset (synchronous, i_rst_n low): pipeline empty, tracking off, residual 0,
// max_gain 16.
`include "drag_detent_quantizer_assert.svh"

module drag_detent_quantizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: max_gain
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ddq_pkg::GAIN_W-1:0]    i_cfg_data,
    // input samples
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ddq_pkg::TDATA_W-1:0]   s_axis_tdata,   // [15:0] pos_y
    input  logic [0:0]                    s_axis_tuser,   // [0] pressed
    // results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ddq_pkg::OTDATA_W-1:0]  m_axis_tdata    // [10:0] value_delta
);
    import ddq_pkg::*;

    localparam logic signed [PROD_W-1:0] GAIN_BASE_S = PROD_W'(GAIN_BASE);

    // control
    logic r_v1, r_v2, r_v3;
    logic adv2, adv3, s_acc;
    logic r_tracking;
    logic [GAIN_W-1:0] r_max_gain;
    logic signed [POS_W-1:0] r_residual;
    logic signed [POS_W-1:0] n_residual;

    // payload
    logic [POS_W-1:0] r_last_pos;
    t_kind r_kind1, r_kind2, n_kind1;
    logic signed [POS_W-1:0] r_dy1;
    logic [GAIN_W-1:0] r_gain1, n_gain1;
    logic signed [POS_W-1:0] r_scaled2;
    logic [OUT_W-1:0] r_out, n_out;

    // stage 1 datapath
    logic signed [POS_W-1:0] n_dy1;
    logic [POS_W-1:0] mag;
    logic [POS_W:0] gain_sum;

    // stage 2 datapath
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] quot;

    // stage 3 datapath
    logic signed [POS_W-1:0] res;
    logic [NUM_W-1:0] num_u;
    logic [QPROD_W-1:0] qprod;
    logic [Q_W-1:0] q;
    logic [NUM_W-1:0] rem;
    logic [OUT_W:0] steps_neg;

    assign o_cfg_ready   = 1'b1;
    assign adv3          = !r_v3 || m_axis_tready;
    assign adv2          = !r_v2 || adv3;
    assign s_axis_tready = !r_v1 || adv2;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(OTDATA_W-OUT_W){1'b0}}, r_out};

    // stage 1: classify, wrapped delta, capped gain
    always_comb begin
        n_dy1    = $signed(s_axis_tdata - r_last_pos);
        mag      = n_dy1[POS_W-1] ? (~n_dy1 + POS_W'(1)) : n_dy1;
        gain_sum = {1'b0, mag} + (POS_W+1)'(GAIN_BASE);
        if (gain_sum > {{(POS_W+1-GAIN_W){1'b0}}, r_max_gain}) begin
            n_gain1 = r_max_gain;
        end else begin
            n_gain1 = gain_sum[GAIN_W-1:0];
        end
        if (!s_axis_tuser[0]) begin
            n_kind1 = KIND_RELEASE;
        end else if (!r_tracking) begin
            n_kind1 = KIND_LATCH;
        end else begin
            n_kind1 = KIND_MOVE;
        end
    end

    // stage 2: scale, truncating toward zero
    always_comb begin
        prod = r_dy1 * $signed({1'b0, r_gain1});
        quot = prod / GAIN_BASE_S;
    end

    // stage 3: residual add and floor division by the pitch; non-move items give 0 and clear the residual
    always_comb begin
        res       = r_residual + r_scaled2;
        num_u     = {res[POS_W-1], res} + NUM_W'(HALF_OFS + BIAS);
        qprod     = QPROD_W'(num_u) * QPROD_W'(DIV_MULT);
        q         = qprod[DIV_SHIFT +: Q_W];
        rem       = num_u - NUM_W'(q) * NUM_W'(PIXELS_PER_STEP);
        steps_neg = (OUT_W+1)'(BIAS_STEPS) - {1'b0, q};
        if (r_kind2 == KIND_MOVE) begin
            n_residual = rem[POS_W-1:0] - POS_W'(HALF_OFS);
            n_out      = steps_neg[OUT_W-1:0];
        end else begin
            n_residual = '0;
            n_out      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_tracking <= 1'b0;
            r_residual <= '0;
            r_max_gain <= MAX_GAIN_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_gain <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (s_acc) begin
                r_tracking <= s_axis_tuser[0];
            end
            if (r_v2 && adv3) begin
                r_residual <= n_residual;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_kind1 <= n_kind1;
            r_dy1   <= n_dy1;
            r_gain1 <= n_gain1;
            if (s_axis_tuser[0]) begin
                r_last_pos <= s_axis_tdata;
            end
        end
        if (r_v1 && adv2) begin
            r_kind2   <= r_kind1;
            r_scaled2 <= quot[POS_W-1:0];
        end
        if (r_v2 && adv3) begin
            r_out <= n_out;
        end
    end

    `DDQ_ASSERT_NEXT(a_track_on_press, i_clk, i_rst_n,
        s_acc && s_axis_tuser[0], r_tracking)
    `DDQ_ASSERT_NEXT(a_residual_clear, i_clk, i_rst_n,
        r_v2 && adv3 && (r_kind2 != KIND_MOVE), r_residual == '0)
    `DDQ_ASSERT_SAME(a_residual_range, i_clk, i_rst_n,
        1'b1, (r_residual >= -HALF_OFS) && (r_residual <= HALF_OFS + 1))
    `DDQ_ASSERT_SAME(a_out_range, i_clk, i_rst_n,
        r_v3, ($signed(r_out) >= -BIAS_STEPS) && ($signed(r_out) <= BIAS_STEPS))
    `DDQ_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n,
        !r_v3, s_axis_tready)

endmodule

[sim/tb_drag_detent_quantizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drag_detent_quantizer
// Streams touch items through the quantizer and checks every step count
// against an in-bench predictor, under several gain caps and idle patterns.
// ----------------------------------------------------------------------------
module tb_drag_detent_quantizer;

    import ddq_pkg::*;

    typedef struct packed {
        logic             pressed;
        logic [POS_W-1:0] pos_y;
    } t_touch;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [GAIN_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;    // [15:0] pos_y
    logic [0:0]           s_axis_tuser = '0;    // [0] pressed
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OTDATA_W-1:0]  m_axis_tdata;         // [10:0] value_delta

    // predictor state
    logic                 track_on = 1'b0;
    logic [POS_W-1:0]     anchor_y = '0;
    logic [POS_W-1:0]     residual_px = '0;
    logic [GAIN_W-1:0]    gain_cap = MAX_GAIN_RESET;

    t_touch               touch_queue[$];
    logic [OUT_W-1:0]     expected_steps[$];
    t_touch               next_touch;
    logic                 sample_taken = 1'b0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_left = 0;
    int                   phase_pushed = 0;
    int                   mismatch_count = 0;

    drag_detent_quantizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // steps committed by one touch item; updates the tracking state
    function automatic logic [OUT_W-1:0] step_detents(input logic pressed,
                                                     input logic [POS_W-1:0] y);
        logic signed [POS_W-1:0] dy;
        logic [POS_W-1:0]        res16;
        int                      mag;
        int                      gain;
        int                      scaled;
        int                      num;
        int                      steps;
        if (!pressed) begin
            track_on    = 1'b0;
            residual_px = '0;
            return '0;
        end
        if (!track_on) begin
            track_on    = 1'b1;
            anchor_y    = y;
            residual_px = '0;
            return '0;
        end
        dy       = y - anchor_y;
        anchor_y = y;
        mag      = (dy < 0) ? -int'(dy) : int'(dy);
        gain     = GAIN_BASE + mag;
        if (gain > int'(gain_cap))
            gain = int'(gain_cap);
        scaled = (int'(dy) * gain) / GAIN_BASE;
        res16  = residual_px + scaled[POS_W-1:0];
        num    = int'($signed(res16)) + HALF_OFS;
        // floor division, not truncation
        steps  = (num >= 0) ? num / PIXELS_PER_STEP
                            : -((-num + PIXELS_PER_STEP - 1) / PIXELS_PER_STEP);
        residual_px = POS_W'(int'($signed(res16)) - steps * PIXELS_PER_STEP);
        return OUT_W'(-steps);
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                   input logic [OUT_W-1:0] got);
        if (mismatch_count < 40)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what,
                     $signed(want), $signed(got));
        mismatch_count++;
    endtask

    function automatic void push_touch(input logic pressed, input logic [POS_W-1:0] y);
        t_touch t;
        t.pressed = pressed;
        t.pos_y   = y;
        touch_queue.push_back(t);
        phase_pushed++;
    endfunction

    // mostly whole drags (press, moves, lift) with some stray lifts and jumps
    task automatic queue_touches(input int count);
        logic [POS_W-1:0] y;
        int               pick;
        int               run;
        int               d;
        phase_pushed = 0;
        while (phase_pushed < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_touch(1'b0, POS_W'($urandom));
            end else if (pick < 12) begin
                push_touch(1'b1, POS_W'($urandom));
            end else begin
                y = POS_W'($urandom);
                push_touch(1'b1, y);
                run = $urandom_range(3, 40);
                repeat (run) begin
                    pick = $urandom_range(99);
                    if (pick < 55)
                        d = $urandom_range(80) - 40;
                    else if (pick < 85)
                        d = $urandom_range(1200) - 600;
                    else
                        d = $urandom;
                    y = y + POS_W'(d);
                    push_touch(1'b1, y);
                end
                push_touch(1'b0, POS_W'($urandom));
            end
        end
    endtask

    task automatic write_gain_cap(input logic [GAIN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        gain_cap = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle;
        do @(negedge i_clk);
        while (touch_queue.size() != 0 || s_axis_tvalid || expected_steps.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [GAIN_W-1:0] cap, input int send_pct,
                             input int recv_pct, input int hold, input int count);
        write_gain_cap(cap);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_left      = hold;
        queue_touches(count);
        wait_idle;
    endtask

    // input side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid = 1'b0;
        end else if (!s_axis_tvalid || sample_taken) begin
            if (touch_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_touch    = touch_queue.pop_front();
                s_axis_tvalid = 1'b1;
                s_axis_tuser  = next_touch.pressed;
                s_axis_tdata  = next_touch.pos_y;
            end else begin
                s_axis_tvalid = 1'b0;
            end
        end
    end

    // result side; a long hold-off is counted down here
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        sample_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_steps.size() == 0)
                report_mismatch("result with no item pending", '0, m_axis_tdata[OUT_W-1:0]);
            else if (m_axis_tdata[OUT_W-1:0] != expected_steps[0])
                report_mismatch("value_delta", expected_steps.pop_front(),
                                m_axis_tdata[OUT_W-1:0]);
            else
                void'(expected_steps.pop_front());
        end
        if (sample_taken)
            expected_steps.push_back(step_detents(s_axis_tuser[0], s_axis_tdata));
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset gain cap: lifts, latch, zero and unit moves,
        // half-pitch and full-pitch moves, huge moves that wrap dy
        push_touch(1'b0, 16'h0000);
        push_touch(1'b0, 16'hFFFF);
        push_touch(1'b1, 16'h0000);
        push_touch(1'b1, 16'h0000);
        push_touch(1'b1, 16'h0001);
        push_touch(1'b1, 16'hFFFF);
        push_touch(1'b1, 16'h0010);
        push_touch(1'b1, 16'h0032);
        push_touch(1'b1, 16'h7FFF);
        push_touch(1'b1, 16'h8000);
        push_touch(1'b1, 16'h0000);     // dy of -32768
        push_touch(1'b1, 16'h7FFF);
        push_touch(1'b1, 16'hFFFF);
        push_touch(1'b0, 16'h5555);
        push_touch(1'b1, 16'h8000);
        push_touch(1'b1, 16'h7FFF);     // wraps to dy of -1
        push_touch(1'b1, 16'h7FEB);
        push_touch(1'b1, 16'h7FD7);
        push_touch(1'b1, 16'h7FC3);
        push_touch(1'b0, 16'hAAAA);
        wait_idle;

        // zero cap: residual never moves
        write_gain_cap('0);
        push_touch(1'b1, 16'h1234);
        push_touch(1'b1, 16'h1428);
        push_touch(1'b1, 16'h1425);
        push_touch(1'b0, 16'h0000);
        wait_idle;

        run_phase(GAIN_W'(1), 0, 0, 0, 325);
        run_phase(GAIN_W'(32767), 45, 0, 0, 325);
        run_phase(GAIN_W'(GAIN_BASE), 0, 45, 0, 325);
        run_phase(GAIN_W'($urandom_range(5, 300)), 20, 20, 0, 325);
        run_phase(MAX_GAIN_RESET, 0, 0, 300, 325);
        run_phase(GAIN_W'($urandom_range(1, 32767)), 20, 20, 0, 325);

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #500000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
